// ----- src/tti_pkg.sv -----
// Shared types, constants and helpers for the trilinear interpolation table.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package tti_pkg;

  localparam int MAX_DIM0_DEF = 16;
  localparam int MAX_DIM1_DEF = 16;
  localparam int MAX_DIM2_DEF = 16;

  localparam int IDX_W     = 8;   // holds any grid index up to 255
  localparam int FRAC_W    = 16;
  localparam int VAL_W     = 32;
  localparam int COORD_W   = 17;
  localparam int SIZE_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int EIDX_W    = 4;
  localparam int IN_DATA_W = 96;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM2 = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One classified item on its way from the front end to the datapath.
  typedef struct packed {
    logic                               is_query;
    logic                               wr_en;
    logic [2:0][IDX_W-1:0]              idx;    // lower corner, or entry index
    logic [2:0][FRAC_W-1:0]             frac;
    logic [VAL_W-1:0]                   value;
  } item_t;

  // Row address bits of one axis inside a parity bank.
  function automatic int row_w(input int max_dim);
    int d;
    d = (max_dim + 1) >> 1;
    return (d > 1) ? $clog2(d) : 1;
  endfunction

endpackage
`default_nettype wire

// ----- src/table_3d_trilinear_interpolator_unit.sv -----
// Trilinear interpolation over a 3-D grid table of signed Q16.16 samples.
// The eight parity banks serve all corners; three blend levels follow the read.
// Throughput: one beat per cycle while the output is not stalled.
// Grid memory is not cleared by reset; read only entries already written.
// Reset (rst_n low, synchronous) sets all sizes to 1 and empties the pipe.
`default_nettype none
module table_3d_trilinear_interpolator_unit #(
  parameter int MAX_DIM0 = tti_pkg::MAX_DIM0_DEF,
  parameter int MAX_DIM1 = tti_pkg::MAX_DIM1_DEF,
  parameter int MAX_DIM2 = tti_pkg::MAX_DIM2_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // operation
  input  wire logic                          in_tuser,
  // entry_index0[3:0], entry_index1[7:4], entry_index2[11:8], entry_value[43:12],
  // coord0[60:44], coord1[77:61], coord2[94:78], zero pad[95]
  input  wire logic [tti_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // interpolated_value[31:0]
  output logic [tti_pkg::VAL_W-1:0]          out_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [tti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tti_pkg::SIZE_W-1:0]    cfg_data
);

  logic           push, pop, full, empty;
  tti_pkg::item_t push_item, head;

  tti_front #(.MAX_DIM0(MAX_DIM0), .MAX_DIM1(MAX_DIM1), .MAX_DIM2(MAX_DIM2)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .cfg_we, .cfg_index, .cfg_data,
    .fifo_full(full), .push, .push_item
  );

  tti_fifo u_fifo (
    .clk, .rst_n, .push, .push_item, .pop, .full, .empty, .head
  );

  tti_back #(.MAX_DIM0(MAX_DIM0), .MAX_DIM1(MAX_DIM1), .MAX_DIM2(MAX_DIM2)) u_back (
    .clk, .rst_n, .empty, .head, .pop, .out_tvalid, .out_tready, .out_tdata
  );

endmodule
`default_nettype wire

// ----- src/tti_front.sv -----
// Front end: size registers, input beat decode, per-axis cell split.
// Depends on tti_pkg.
`default_nettype none
module tti_front #(
  parameter int MAX_DIM0 = tti_pkg::MAX_DIM0_DEF,
  parameter int MAX_DIM1 = tti_pkg::MAX_DIM1_DEF,
  parameter int MAX_DIM2 = tti_pkg::MAX_DIM2_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic                          in_tuser,
  input  wire logic [tti_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [tti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tti_pkg::SIZE_W-1:0]    cfg_data,
  input  wire logic                          fifo_full,
  output logic                               push,
  output tti_pkg::item_t                     push_item
);

  localparam int MAXD [3] = '{MAX_DIM0, MAX_DIM1, MAX_DIM2};

  logic [tti_pkg::SIZE_W-1:0] size_r [3];
  logic [tti_pkg::IDX_W-1:0]  lo_w   [3];
  logic [tti_pkg::FRAC_W-1:0] frac_w [3];
  logic [2:0]                 ok_w;
  logic                       is_query;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0] <= tti_pkg::SIZE_W'(1);
      size_r[1] <= tti_pkg::SIZE_W'(1);
      size_r[2] <= tti_pkg::SIZE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tti_pkg::CFG_SIZE_DIM0: size_r[0] <= cfg_data;
        tti_pkg::CFG_SIZE_DIM1: size_r[1] <= cfg_data;
        tti_pkg::CFG_SIZE_DIM2: size_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_query = (in_tuser == tti_pkg::OP_QUERY);

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic [tti_pkg::COORD_W-1:0] coord;
    logic [tti_pkg::EIDX_W-1:0]  eidx;
    logic [tti_pkg::IDX_W:0]     n_eff;
    logic [tti_pkg::IDX_W-1:0]   nm1;
    logic [tti_pkg::COORD_W-1:0] c_sat;
    logic [24:0]                 t;
    logic [tti_pkg::IDX_W-1:0]   i_c;
    logic [tti_pkg::FRAC_W-1:0]  f_c;

    assign coord = in_tdata[44 + 17*k +: tti_pkg::COORD_W];
    assign eidx  = in_tdata[4*k +: tti_pkg::EIDX_W];

    always_comb begin
      if (size_r[k] == '0)
        n_eff = (tti_pkg::IDX_W+1)'(1);
      else if ((tti_pkg::IDX_W+1)'(size_r[k]) > (tti_pkg::IDX_W+1)'(MAXD[k]))
        n_eff = (tti_pkg::IDX_W+1)'(MAXD[k]);
      else
        n_eff = (tti_pkg::IDX_W+1)'(size_r[k]);
      nm1   = tti_pkg::IDX_W'(n_eff - (tti_pkg::IDX_W+1)'(1));
      c_sat = (coord > 17'h10000) ? 17'h10000 : coord;
      t     = 25'(c_sat) * 25'(nm1);
      i_c   = t[23:16];
      f_c   = t[15:0];
      // last index: hold there with no fraction
      if (i_c >= nm1) begin
        i_c = nm1;
        f_c = '0;
      end
    end

    assign lo_w[k]   = is_query ? i_c : tti_pkg::IDX_W'(eidx);
    assign frac_w[k] = is_query ? f_c : '0;
    assign ok_w[k]   = (tti_pkg::IDX_W+1)'(eidx) < (tti_pkg::IDX_W+1)'(MAXD[k]);
  end

  assign in_tready = !fifo_full;
  assign push      = in_tvalid && !fifo_full;

  always_comb begin
    push_item.is_query = is_query;
    push_item.wr_en    = !is_query && (&ok_w);
    push_item.value    = in_tdata[12 +: tti_pkg::VAL_W];
    for (int k = 0; k < 3; k++) begin
      push_item.idx[k]  = lo_w[k];
      push_item.frac[k] = frac_w[k];
    end
  end

endmodule
`default_nettype wire

// ----- src/tti_fifo.sv -----
// Short queue between the front end and the datapath.
// Depends on tti_pkg.
`default_nettype none
module tti_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  tti_pkg::item_t      push_item,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output tti_pkg::item_t      head
);

  localparam int PW = $clog2(tti_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(tti_pkg::FIFO_DEPTH + 1);

  tti_pkg::item_t slot_r [tti_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full  = (count_r == CW'(tti_pkg::FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == PW'(tti_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == PW'(tti_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      priority if (push && !pop) count_r <= count_r + CW'(1);
      else if (pop && !push)     count_r <= count_r - CW'(1);
      else                       count_r <= count_r;
    end
  end

endmodule
`default_nettype wire

// ----- src/tti_back.sv -----
// Datapath: eight parity-banked grid memories, then three blend levels,
// each a multiply stage and an add stage. Depends on tti_pkg.
`default_nettype none
module tti_back #(
  parameter int MAX_DIM0 = tti_pkg::MAX_DIM0_DEF,
  parameter int MAX_DIM1 = tti_pkg::MAX_DIM1_DEF,
  parameter int MAX_DIM2 = tti_pkg::MAX_DIM2_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      empty,
  input  tti_pkg::item_t                 head,
  output logic                           pop,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [tti_pkg::VAL_W-1:0]      out_tdata
);

  localparam int RW0 = tti_pkg::row_w(MAX_DIM0);
  localparam int RW1 = tti_pkg::row_w(MAX_DIM1);
  localparam int RW2 = tti_pkg::row_w(MAX_DIM2);
  localparam int AW  = RW0 + RW1 + RW2;
  localparam int BANK_D = 2 ** AW;
  localparam int IW  = tti_pkg::IDX_W;
  localparam int FW  = tti_pkg::FRAC_W;

  // Element of one axis that lives in the bank of the given parity.
  function automatic logic [IW-1:0] pick_elem(input logic [IW-1:0] lo, input logic par,
                                              input int maxd);
    logic [IW:0] e;
    e = {1'b0, lo} + {{IW{1'b0}}, lo[0] ^ par};
    // only past the table edge when the upper neighbor is clamped anyway
    if (e >= (IW+1)'(maxd)) e = {1'b0, lo};
    return e[IW-1:0];
  endfunction

  function automatic logic signed [49:0] bmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [FW-1:0] f);
    logic signed [31:0] bb;
    logic signed [32:0] d;
    bb = (f == '0) ? a : b;
    d  = 33'(bb) - 33'(a);
    return 50'(d * $signed({1'b0, f}));
  endfunction

  function automatic logic signed [31:0] badd(input logic signed [31:0] a,
                                              input logic signed [49:0] m);
    logic signed [33:0] s;
    s = 34'(a) + $signed(m[49:16]);
    return s[31:0];
  endfunction

  logic adv;
  logic out_valid_r;
  logic signed [31:0] out_data_r;

  assign adv = !out_valid_r || out_tready;
  assign pop = adv && !empty;

  logic signed [31:0] rd_data [8];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [31:0]   mem [BANK_D];
    logic [IW-1:0] e0, e1, e2, h0, h1, h2;
    logic [AW-1:0] addr;
    logic          we;
    logic [31:0]   rdata_r;

    assign e0 = pick_elem(head.idx[0], 1'(b & 1), MAX_DIM0);
    assign e1 = pick_elem(head.idx[1], 1'((b >> 1) & 1), MAX_DIM1);
    assign e2 = pick_elem(head.idx[2], 1'((b >> 2) & 1), MAX_DIM2);
    assign h0 = e0 >> 1;
    assign h1 = e1 >> 1;
    assign h2 = e2 >> 1;
    assign addr = {h0[RW0-1:0], h1[RW1-1:0], h2[RW2-1:0]};
    assign we = pop && head.wr_en &&
                (head.idx[0][0] == 1'(b & 1)) &&
                (head.idx[1][0] == 1'((b >> 1) & 1)) &&
                (head.idx[2][0] == 1'((b >> 2) & 1));

    always_ff @(posedge clk) begin
      if (we) mem[addr] <= head.value;
    end

    always_ff @(posedge clk) begin
      if (adv) rdata_r <= mem[addr];
    end

    assign rd_data[b] = $signed(rdata_r);
  end

  // read stage
  logic          v1_r;
  logic [FW-1:0] fr1_r [3];
  logic [2:0]    par1_r;
  logic signed [31:0] corner [8];

  always_comb begin
    for (int k = 0; k < 8; k++)
      corner[k] = rd_data[3'(k) ^ par1_r];
  end

  // level stages
  logic v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [FW-1:0] fr2_r [2];
  logic [FW-1:0] fr3_r [2];
  logic [FW-1:0] fr4_r, fr5_r;
  logic signed [31:0] a2_r [4];
  logic signed [49:0] m2_r [4];
  logic signed [31:0] s3_r [4];
  logic signed [31:0] a4_r [2];
  logic signed [49:0] m4_r [2];
  logic signed [31:0] s5_r [2];
  logic signed [31:0] a6_r;
  logic signed [49:0] m6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r <= pop && head.is_query;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) fr1_r[k] <= head.frac[k];
      par1_r <= {head.idx[2][0], head.idx[1][0], head.idx[0][0]};
      for (int j = 0; j < 4; j++) begin
        a2_r[j] <= corner[2*j];
        m2_r[j] <= bmul(corner[2*j], corner[2*j+1], fr1_r[0]);
        s3_r[j] <= badd(a2_r[j], m2_r[j]);
      end
      fr2_r[0] <= fr1_r[1];
      fr2_r[1] <= fr1_r[2];
      fr3_r[0] <= fr2_r[0];
      fr3_r[1] <= fr2_r[1];
      for (int j = 0; j < 2; j++) begin
        a4_r[j] <= s3_r[2*j];
        m4_r[j] <= bmul(s3_r[2*j], s3_r[2*j+1], fr3_r[0]);
        s5_r[j] <= badd(a4_r[j], m4_r[j]);
      end
      fr4_r <= fr3_r[1];
      fr5_r <= fr4_r;
      a6_r  <= s5_r[0];
      m6_r  <= bmul(s5_r[0], s5_r[1], fr5_r);
      out_data_r <= badd(a6_r, m6_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r, v6_r}))
    else $error("pipeline moved during output stall");
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !head.is_query) |=> !v1_r)
    else $error("table write entered the blend pipeline");
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && adv) |=> out_valid_r)
    else $error("final blend lost before output register");
`endif

endmodule
`default_nettype wire

// ----- verif/table_3d_trilinear_interpolator_unit_tb.sv -----
// Testbench for table_3d_trilinear_interpolator_unit: grid writes and trilinear queries.
// It checks each result against an in-bench model or a set value. It depends on tti_pkg.
`timescale 1ns / 100ps
`default_nettype none
module table_3d_trilinear_interpolator_unit_tb;

  localparam int GRID_N      = 16;
  localparam int DRAIN_WAIT  = 20;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 50;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic             op;
    logic [3:0]       e0, e1, e2;
    logic [31:0]      val;
    logic [16:0]      c0, c1, c2;
    bit               typed;
    logic [31:0]      want;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic in_tuser = 1'b0;
  logic [tti_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tti_pkg::VAL_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [tti_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tti_pkg::SIZE_W-1:0] cfg_data = '0;

  // grid contents and register copies for prediction
  logic [31:0] grid [GRID_N][GRID_N][GRID_N];
  bit          grid_valid [GRID_N][GRID_N][GRID_N];
  logic [4:0]  dim_size [3];

  logic [31:0] pending_values[$];
  int          fail_count = 0;
  int          quiet_cycles = 0;
  idle_mode_t  idle_mode = IDLE_NONE;
  bit          hold_req = 1'b0;

  always #5 clk = ~clk;

  table_3d_trilinear_interpolator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic int eff_dim(input logic [4:0] r);
    if (r == 5'd0) return 1;
    if (int'(r) > GRID_N) return GRID_N;
    return int'(r);
  endfunction

  function automatic void split_coord(input logic [16:0] c, input int n,
                                      output int lo, output int hi, output longint fr);
    logic [31:0] t;
    logic [31:0] cs;
    int i;
    cs = (c > 17'd65536) ? 32'd65536 : {15'd0, c};
    t = cs * 32'(n - 1);
    i = int'(t >> 16);
    fr = longint'(t[15:0]);
    if (i >= n - 1) begin
      i = n - 1;
      fr = 0;
    end
    lo = i;
    hi = (i + 1 < n) ? i + 1 : i;
  endfunction

  function automatic longint lerp(input longint a, input longint b, input longint f);
    return a + (((b - a) * f) >>> 16);
  endfunction

  function automatic longint grid_at(input int i0, input int i1, input int i2);
    return longint'($signed(grid[i0][i1][i2]));
  endfunction

  function automatic logic [31:0] interpolate(input logic [16:0] c0, c1, c2);
    int a0, b0, a1, b1, a2, b2;
    longint f0, f1, f2, v00, v10, v01, v11, v0, v1, r;
    split_coord(c0, eff_dim(dim_size[0]), a0, b0, f0);
    split_coord(c1, eff_dim(dim_size[1]), a1, b1, f1);
    split_coord(c2, eff_dim(dim_size[2]), a2, b2, f2);
    v00 = lerp(grid_at(a0, a1, a2), grid_at(b0, a1, a2), f0);
    v10 = lerp(grid_at(a0, b1, a2), grid_at(b0, b1, a2), f0);
    v01 = lerp(grid_at(a0, a1, b2), grid_at(b0, a1, b2), f0);
    v11 = lerp(grid_at(a0, b1, b2), grid_at(b0, b1, b2), f0);
    v0 = lerp(v00, v10, f1);
    v1 = lerp(v01, v11, f1);
    r = lerp(v0, v1, f2);
    return r[31:0];
  endfunction

  task automatic send_beat(input beat_t b);
    int pct;
    pct = 0;
    if (idle_mode == IDLE_SEND) pct = 59;
    else if (idle_mode == IDLE_BOTH) pct = 24;
    // insert idle cycles by repeated draws so the idle share matches pct
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = b.op;
    in_tdata = {1'b0, b.c2, b.c1, b.c0, b.val, b.e2, b.e1, b.e0};
    do @(posedge clk); while (!in_tready);
    // beat accepted at this edge: update the model in acceptance order
    if (b.op == tti_pkg::OP_WRITE) begin
      grid[b.e0][b.e1][b.e2] = b.val;
      grid_valid[b.e0][b.e1][b.e2] = 1'b1;
    end else begin
      pending_values.push_back(b.typed ? b.want : interpolate(b.c0, b.c1, b.c2));
    end
  endtask

  task automatic write_reg(input logic [tti_pkg::CFG_IDX_W-1:0] idx, input logic [4:0] v);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    dim_size[idx] = v;
  endtask

  function automatic logic [16:0] rand_coord();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(131071, 65537));
      default: return 17'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic beat_t rand_beat(input logic op);
    beat_t b;
    b.op = op;
    b.e0 = 4'($urandom_range(15));
    b.e1 = 4'($urandom_range(15));
    b.e2 = 4'($urandom_range(15));
    b.val = rand_value();
    b.c0 = rand_coord();
    b.c1 = rand_coord();
    b.c2 = rand_coord();
    b.typed = 1'b0;
    b.want = '0;
    return b;
  endfunction

  // Fill any corner the query will touch that was never written, then send it.
  task automatic send_query(input beat_t q);
    int lo[3], hi[3];
    longint fr;
    beat_t w;
    split_coord(q.c0, eff_dim(dim_size[0]), lo[0], hi[0], fr);
    split_coord(q.c1, eff_dim(dim_size[1]), lo[1], hi[1], fr);
    split_coord(q.c2, eff_dim(dim_size[2]), lo[2], hi[2], fr);
    for (int k = 0; k < 8; k++) begin
      w = rand_beat(tti_pkg::OP_WRITE);
      w.e0 = 4'(k[0] ? hi[0] : lo[0]);
      w.e1 = 4'(k[1] ? hi[1] : lo[1]);
      w.e2 = 4'(k[2] ? hi[2] : lo[2]);
      if (!grid_valid[w.e0][w.e1][w.e2]) send_beat(w);
    end
    send_beat(q);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_values.size() == 0) begin
        $error("interpolated_value with no query pending: actual %h", out_tdata);
        fail_count++;
      end else begin
        if (out_tdata !== pending_values[0]) begin
          $error("interpolated_value mismatch: expected %h, actual %h",
                 pending_values[0], out_tdata);
          fail_count++;
        end
        void'(pending_values.pop_front());
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_req) begin
      out_tready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end
    if (idle_mode == IDLE_RECV)
      out_tready = ($urandom_range(99) >= 59);
    else if (idle_mode == IDLE_BOTH)
      out_tready = ($urandom_range(99) >= 24);
    else
      out_tready = 1'b1;
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  beat_t directed [$];
  logic [4:0] phase_sizes [6][3] = '{
    '{5'd16, 5'd16, 5'd16}, '{5'd0, 5'd31, 5'd2}, '{5'd2, 5'd1, 5'd16},
    '{5'd5, 5'd7, 5'd3}, '{5'd31, 5'd0, 5'd9}, '{5'd16, 5'd4, 5'd1}
  };

  initial begin
    beat_t b;
    dim_size[0] = 5'd1;
    dim_size[1] = 5'd1;
    dim_size[2] = 5'd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: all sizes 1 after reset, so every query returns entry (0,0,0)
    b = rand_beat(tti_pkg::OP_WRITE);
    b.e0 = 4'd0; b.e1 = 4'd0; b.e2 = 4'd0; b.val = 32'h7fff_ffff;
    directed.push_back(b);
    b = rand_beat(tti_pkg::OP_QUERY);
    b.c0 = 17'd0; b.c1 = 17'd0; b.c2 = 17'd0; b.typed = 1'b1; b.want = 32'h7fff_ffff;
    directed.push_back(b);
    b.c0 = 17'h1ffff; b.c1 = 17'd65536; b.c2 = 17'd65535;
    directed.push_back(b);
    b = rand_beat(tti_pkg::OP_WRITE);
    b.e0 = 4'd15; b.e1 = 4'd15; b.e2 = 4'd15; b.val = 32'h8000_0000;
    directed.push_back(b);
    b = rand_beat(tti_pkg::OP_WRITE);
    b.e0 = 4'd0; b.e1 = 4'd0; b.e2 = 4'd0; b.val = 32'h8000_0000;
    directed.push_back(b);
    b = rand_beat(tti_pkg::OP_QUERY);
    b.c0 = 17'd65536; b.c1 = 17'd65536; b.c2 = 17'd65536;
    b.typed = 1'b1; b.want = 32'h8000_0000;
    directed.push_back(b);
    b = rand_beat(tti_pkg::OP_WRITE);
    b.e0 = 4'd0; b.e1 = 4'd0; b.e2 = 4'd0; b.val = 32'hffff_ffff;
    directed.push_back(b);
    for (int k = 0; k < 6; k++) begin
      b = rand_beat(tti_pkg::OP_QUERY);
      directed.push_back(b);
    end
    foreach (directed[r]) send_beat(directed[r]);

    // extremes of size: full grid, corners at 0 and 1.0 on every axis
    write_reg(tti_pkg::CFG_SIZE_DIM0, 5'd16);
    write_reg(tti_pkg::CFG_SIZE_DIM1, 5'd16);
    write_reg(tti_pkg::CFG_SIZE_DIM2, 5'd16);
    for (int k = 0; k < 8; k++) begin
      b = rand_beat(tti_pkg::OP_QUERY);
      b.c0 = k[0] ? 17'd65536 : 17'd0;
      b.c1 = k[1] ? 17'd65536 : 17'd0;
      b.c2 = k[2] ? 17'd65536 : 17'd0;
      send_query(b);
    end

    for (int p = 0; p < 8; p++) begin
      if (p < 6) begin
        for (int d = 0; d < 3; d++)
          write_reg(d[tti_pkg::CFG_IDX_W-1:0], phase_sizes[p][d]);
      end else begin
        for (int d = 0; d < 3; d++)
          write_reg(d[tti_pkg::CFG_IDX_W-1:0], 5'($urandom_range(31)));
      end
      idle_mode = idle_mode_t'(p % 4);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 15) send_beat(rand_beat(tti_pkg::OP_WRITE));
        else send_query(rand_beat(tti_pkg::OP_QUERY));
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
